@@ design/spi_adc_channel_scan_macros.svh @@
// assertion macros shared by the channel scan checker
`ifndef SPI_ADC_CHANNEL_SCAN_MACROS_SVH
`define SPI_ADC_CHANNEL_SCAN_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SACS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("channel scan check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("channel scan check failed");

`endif

@@ design/sacs_pkg.sv @@
// shared types and constants of the channel scan block
package sacs_pkg;

    // sizing defaults
    localparam int DEF_MAX_SENSORS = 8;
    localparam int DEF_READ_BITS   = 12;
    localparam int DEF_QUEUE_DEPTH = 4;

    // command framing: start, single-ended, 3-bit channel
    localparam int COMMAND_BITS   = 5;
    localparam int PH_CMD_START   = 3;
    localparam int PH_READ_START  = PH_CMD_START + 3 * COMMAND_BITS;
    localparam logic [1:0] CMD_PREFIX = 2'b11;

    // widest code the scaler takes (READ_BITS up to 16)
    localparam int CODE_MAX_W = 15;
    localparam int RAW_W      = 11;

    // rounding divide by full scale: ceil(2^42 / 1023) is exact for |num| < 2^31
    localparam int FULL_SCALE  = 1023;
    localparam int RECIP_SHIFT = 42;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE - 1)) / 64'(FULL_SCALE);
    localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];
    localparam int MAG_W   = 31;
    localparam int QUO_W   = 22;
    localparam logic [32:0] ROUND_HALF = 33'(FULL_SCALE / 2);

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SENSOR_COUNT = 2'd0,
        REG_CHANNEL_MAP  = 2'd1,
        REG_MIN_EXT      = 2'd2,
        REG_MAX_EXT      = 2'd3
    } sacs_reg_t;

    localparam logic [3:0]  RST_SENSOR_COUNT = 4'd8;
    localparam logic [23:0] RST_CHANNEL_MAP  = 24'd16434824;
    localparam logic [15:0] RST_MIN_EXT      = 16'd0;
    localparam logic [15:0] RST_MAX_EXT      = 16'd256;

    // command bit sub-steps
    typedef enum logic [2:0] {
        STEP_DRIVE = 3'b001,
        STEP_RISE  = 3'b010,
        STEP_FALL  = 3'b100
    } sacs_step_t;

    typedef struct packed {
        logic [3:0]  sensor_count;
        logic [23:0] channel_map;
        logic [15:0] min_ext;
        logic [15:0] max_ext;
    } sacs_cfg_t;

    // one classified tick between front and back
    typedef struct packed {
        logic                  cs;
        logic                  sclk;
        logic                  mosi;
        logic                  valid;
        logic [2:0]            idx;
        logic [CODE_MAX_W-1:0] code;
        logic [RAW_W-1:0]      raw;
        logic                  last;
        logic                  busy;
        logic [15:0]           lo;
        logic [15:0]           hi;
    } sacs_item_t;

    // one finished request on the result side
    typedef struct packed {
        logic             cs;
        logic             sclk;
        logic             mosi;
        logic             valid;
        logic [2:0]       idx;
        logic [RAW_W-1:0] raw;
        logic [15:0]      ext;
        logic             last;
        logic             busy;
    } sacs_result_t;

endpackage

@@ design/sacs_queue.sv @@
// short queue of classified ticks between sequencer and scaler
module sacs_queue
    import sacs_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  sacs_item_t wr_item,
    output logic       full,
    input  logic       rd_en,
    output logic       rd_valid,
    output sacs_item_t rd_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sacs_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;
    assign rd_item  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ design/sacs_front.sv @@
// pin sequencer: one pin action per accepted tick
module sacs_front
    import sacs_pkg::*;
#(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS,
    parameter int READ_BITS   = DEF_READ_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sacs_cfg_t  cfg,
    input  logic       accept,
    input  logic       start_req,
    input  logic       miso,
    output sacs_item_t item
);

    localparam int PH_END = PH_READ_START + 2 * READ_BITS;
    localparam int PH_W   = $clog2(PH_END + 1);
    localparam logic [3:0] MAX_CNT = 4'(MAX_SENSORS);

    logic [PH_W-1:0]      phase_reg, phase_next;
    logic [2:0]           sensor_reg, sensor_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [READ_BITS-1:0] recv_reg, recv_next;
    sacs_step_t           step_reg, step_next;
    logic                 active_reg, active_next;
    logic                 cs_reg, cs_next;
    logic                 sclk_reg, sclk_next;
    logic                 mosi_reg, mosi_next;

    logic                  start_now;
    logic                  run;
    logic [PH_W-1:0]       phase_cur;
    logic [PH_W-1:0]       ph_rel;
    logic [2:0]            sensor_cur;
    logic [3:0]            sensor_inc;
    logic [3:0]            eff_count;
    logic [7:0][2:0]       chan_arr;
    logic [2:0]            channel;
    logic [CODE_MAX_W-1:0] code_wide;

    // clamp the sensor count to 1..MAX_SENSORS
    always_comb
    begin
        if (cfg.sensor_count == 4'd0)
        begin
            eff_count = 4'd1;
        end
        else if (cfg.sensor_count > MAX_CNT)
        begin
            eff_count = MAX_CNT;
        end
        else
        begin
            eff_count = cfg.sensor_count;
        end
    end

    assign start_now  = !active_reg && start_req;
    assign run        = active_reg || start_req;
    assign phase_cur  = start_now ? '0 : phase_reg;
    assign sensor_cur = start_now ? '0 : sensor_reg;
    assign ph_rel     = phase_cur - PH_W'(PH_READ_START);
    assign sensor_inc = {1'b0, sensor_cur} + 4'd1;
    assign chan_arr   = cfg.channel_map;
    assign channel    = chan_arr[sensor_cur];
    assign code_wide  = CODE_MAX_W'(recv_reg[READ_BITS-1:1]);

    // pin action for the current phase
    always_comb
    begin
        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        cmd_next    = cmd_reg;
        recv_next   = recv_reg;
        step_next   = step_reg;
        active_next = active_reg;
        cs_next     = cs_reg;
        sclk_next   = sclk_reg;
        mosi_next   = mosi_reg;
        item        = '0;
        if (run)
        begin
            active_next = 1'b1;
            sensor_next = sensor_cur;
            phase_next  = phase_cur + 1'b1;
            priority if (phase_cur == PH_W'(0))
            begin
                cs_next = 1'b1;
            end
            else if (phase_cur == PH_W'(1))
            begin
                sclk_next = 1'b0;
            end
            else if (phase_cur == PH_W'(2))
            begin
                cs_next   = 1'b0;
                cmd_next  = {CMD_PREFIX, channel, 3'b000};
                recv_next = '0;
                step_next = STEP_DRIVE;
            end
            else if (phase_cur < PH_W'(PH_READ_START))
            begin
                // command bit: drive, rise, fall
                unique case (step_reg)
                    STEP_DRIVE:
                    begin
                        mosi_next = cmd_reg[7];
                        cmd_next  = {cmd_reg[6:0], 1'b0};
                        step_next = STEP_RISE;
                    end
                    STEP_RISE:
                    begin
                        sclk_next = 1'b1;
                        step_next = STEP_FALL;
                    end
                    STEP_FALL:
                    begin
                        sclk_next = 1'b0;
                        step_next = STEP_DRIVE;
                    end
                    default:
                    begin
                        step_next = STEP_DRIVE;
                    end
                endcase
            end
            else if (phase_cur < PH_W'(PH_END))
            begin
                // read bit: rise, then fall and sample
                if (!ph_rel[0])
                begin
                    sclk_next = 1'b1;
                end
                else
                begin
                    sclk_next = 1'b0;
                    recv_next = {recv_reg[READ_BITS-2:0], miso};
                end
            end
            else
            begin
                // end of conversion: release chip select, hand off the code
                cs_next    = 1'b1;
                phase_next = '0;
                item.valid = 1'b1;
                item.idx   = sensor_cur;
                item.code  = code_wide;
                item.raw   = code_wide[RAW_W-1:0];
                if (sensor_inc >= eff_count)
                begin
                    item.last   = 1'b1;
                    active_next = 1'b0;
                    sensor_next = '0;
                end
                else
                begin
                    sensor_next = sensor_inc[2:0];
                end
            end
        end
        item.cs   = cs_next;
        item.sclk = sclk_next;
        item.mosi = mosi_next;
        item.busy = active_next;
        item.lo   = cfg.min_ext;
        item.hi   = cfg.max_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            sensor_reg <= '0;
            cmd_reg    <= '0;
            recv_reg   <= '0;
            step_reg   <= STEP_DRIVE;
            active_reg <= 1'b0;
            cs_reg     <= 1'b1;
            sclk_reg   <= 1'b0;
            mosi_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            cmd_reg    <= cmd_next;
            recv_reg   <= recv_next;
            step_reg   <= step_next;
            active_reg <= active_next;
            cs_reg     <= cs_next;
            sclk_reg   <= sclk_next;
            mosi_reg   <= mosi_next;
        end
    end

endmodule

@@ design/sacs_back.sv @@
// scaling pipeline: min + round(code*(max-min)/1023), saturated
module sacs_back
    import sacs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  sacs_item_t   q_item,
    output logic         q_pop,
    input  logic         res_pop,
    output logic         res_empty,
    output sacs_result_t res
);

    logic         s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    sacs_item_t   s1_item_reg, s2_item_reg, s3_item_reg;
    logic signed [32:0] s1_prod_reg;
    logic [MAG_W-1:0]   s2_mag_reg;
    logic               s2_neg_reg, s3_neg_reg;
    logic [QUO_W-1:0]   s3_quo_reg;
    sacs_result_t       s4_res_reg, s4_res_next;

    logic               en;
    logic signed [16:0] diff;
    logic signed [32:0] prod;
    logic [32:0]        abs_val;
    logic [32:0]        mag_sum;
    logic [63:0]        scaled_full;
    logic signed [23:0] lo_wide;
    logic signed [23:0] quo_wide;
    logic signed [23:0] sum;
    logic [15:0]        sat;

    assign en        = !s4_valid_reg || res_pop;
    assign q_pop     = en && q_valid;
    assign res_empty = !s4_valid_reg;
    assign res       = s4_res_reg;

    // stage 1: product of code and span
    assign diff = $signed({q_item.hi[15], q_item.hi}) - $signed({q_item.lo[15], q_item.lo});
    assign prod = 33'($signed({2'b00, q_item.code})) * 33'(diff);

    // stage 2: magnitude plus half for round to nearest
    assign abs_val = s1_prod_reg[32] ? 33'(-s1_prod_reg) : 33'(s1_prod_reg);
    assign mag_sum = abs_val + ROUND_HALF;

    // stage 3: divide by full scale through the reciprocal
    assign scaled_full = 64'(s2_mag_reg) * 64'(RECIP);

    // stage 4: offset, sign and saturate
    assign lo_wide  = 24'($signed(s3_item_reg.lo));
    assign quo_wide = $signed({2'b00, s3_quo_reg});
    assign sum      = s3_neg_reg ? (lo_wide - quo_wide) : (lo_wide + quo_wide);

    always_comb
    begin
        if (sum > 24'sd32767)
        begin
            sat = 16'h7FFF;
        end
        else if (sum < -24'sd32768)
        begin
            sat = 16'h8000;
        end
        else
        begin
            sat = sum[15:0];
        end
        s4_res_next.cs    = s3_item_reg.cs;
        s4_res_next.sclk  = s3_item_reg.sclk;
        s4_res_next.mosi  = s3_item_reg.mosi;
        s4_res_next.valid = s3_item_reg.valid;
        s4_res_next.idx   = s3_item_reg.idx;
        s4_res_next.raw   = s3_item_reg.raw;
        s4_res_next.ext   = s3_item_reg.valid ? sat : 16'd0;
        s4_res_next.last  = s3_item_reg.last;
        s4_res_next.busy  = s3_item_reg.busy;
    end

    // stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= q_item;
            s1_prod_reg <= prod;
            s2_item_reg <= s1_item_reg;
            s2_neg_reg  <= s1_prod_reg[32];
            s2_mag_reg  <= mag_sum[MAG_W-1:0];
            s3_item_reg <= s2_item_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_quo_reg  <= scaled_full[RECIP_SHIFT +: QUO_W];
            s4_res_reg  <= s4_res_next;
        end
    end

endmodule

@@ design/spi_adc_channel_scan.sv @@
// top level of the bit-banged SPI channel scanner
//
// Each request on the input queue port (push/full) is one tick: start_req
// and the sampled miso level. Every tick gives exactly one request on the
// result queue port (empty/pop) with the pin levels after that tick and,
// on the tick that ends a conversion, the sensor index, the raw code and
// the scaled Q8.8 value. One sensor takes 43 ticks at READ_BITS = 12.
// Throughput is one tick per cycle while pop keeps up: the sequencer
// finishes a tick in the cycle it is accepted, and the scaler is a
// four-stage pipeline. An accepted tick is written to the tick queue,
// then passes the four scaler stages (multiply, magnitude, reciprocal
// multiply, offset and saturate) before its result shows on the port.
// When pop stays low the scaler holds, the tick queue fills, and full
// rises; the sequencer state moves only on accepted ticks, so no pin
// action is lost. Reset puts the pins at chip select high, clock and data
// low, idle, with empty high; the APB registers take their default values
// and are meant to be written while no sweep is in progress.
module spi_adc_channel_scan
    import sacs_pkg::*;
#(
    parameter int MAX_SENSORS = DEF_MAX_SENSORS,
    parameter int READ_BITS   = DEF_READ_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // ticks
    input  logic               push,
    output logic               full,
    input  logic               start_req,
    input  logic               miso,
    // results
    output logic               empty,
    input  logic               pop,
    output logic               chip_select,
    output logic               spi_clock,
    output logic               mosi,
    output logic               result_valid,
    output logic [2:0]         sensor_index,
    output logic [RAW_W-1:0]   raw_code,
    output logic signed [15:0] extension,
    output logic               last_sensor,
    output logic               busy_res
);

    sacs_cfg_t    cfg_reg;
    sacs_item_t   front_item;
    sacs_item_t   q_item;
    sacs_result_t res;
    logic         accept;
    logic         q_valid;
    logic         q_pop;
    logic         cfg_wr;
    sacs_reg_t    reg_sel;

    // register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_sel = sacs_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_count <= RST_SENSOR_COUNT;
            cfg_reg.channel_map  <= RST_CHANNEL_MAP;
            cfg_reg.min_ext      <= RST_MIN_EXT;
            cfg_reg.max_ext      <= RST_MAX_EXT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_SENSOR_COUNT: cfg_reg.sensor_count <= pwdata[3:0];
                REG_CHANNEL_MAP:  cfg_reg.channel_map  <= pwdata[23:0];
                REG_MIN_EXT:      cfg_reg.min_ext      <= pwdata[15:0];
                REG_MAX_EXT:      cfg_reg.max_ext      <= pwdata[15:0];
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_SENSOR_COUNT: prdata = DATA_W'(cfg_reg.sensor_count);
            REG_CHANNEL_MAP:  prdata = DATA_W'(cfg_reg.channel_map);
            REG_MIN_EXT:      prdata = DATA_W'(cfg_reg.min_ext);
            REG_MAX_EXT:      prdata = DATA_W'(cfg_reg.max_ext);
        endcase
    end

    assign accept = push && !full;

    sacs_front #(
        .MAX_SENSORS (MAX_SENSORS),
        .READ_BITS   (READ_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .accept    (accept),
        .start_req (start_req),
        .miso      (miso),
        .item      (front_item)
    );

    sacs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_item  (front_item),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    sacs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_pop   (pop),
        .res_empty (empty),
        .res       (res)
    );

    // result fields
    assign chip_select  = res.cs;
    assign spi_clock    = res.sclk;
    assign mosi         = res.mosi;
    assign result_valid = res.valid;
    assign sensor_index = res.idx;
    assign raw_code     = res.raw;
    assign extension    = $signed(res.ext);
    assign last_sensor  = res.last;
    assign busy_res     = res.busy;

endmodule

@@ design/sacs_checker.sv @@
// port-level checks of the channel scan block, bound to the top level
`include "spi_adc_channel_scan_macros.svh"

module sacs_checker
    import sacs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic               chip_select,
    input logic               result_valid,
    input logic [2:0]         sensor_index,
    input logic [RAW_W-1:0]   raw_code,
    input logic signed [15:0] extension,
    input logic               last_sensor,
    input logic               busy_res
);

    // a tick without a conversion carries no measurement
    `SACS_ASSERT_NOW(a_idle_fields_zero, !empty && !result_valid, sensor_index == 3'd0 && raw_code == '0 && extension == 16'sd0 && !last_sensor)

    // a conversion ends with chip select released
    `SACS_ASSERT_NOW(a_result_cs_high, !empty && result_valid, chip_select)

    // the sweep stays busy exactly until its final sensor
    `SACS_ASSERT_NOW(a_busy_vs_last, !empty && result_valid, busy_res == !last_sensor)

    // a waiting request is held until taken
    `SACS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(extension) && $stable(chip_select))

endmodule

bind spi_adc_channel_scan sacs_checker u_sacs_checker (.*);

@@ test/tb_spi_adc_channel_scan.sv @@
// self-checking testbench for the bit-banged SPI channel scanner
module tb_spi_adc_channel_scan;
    import sacs_pkg::*;

    localparam int PH_END      = PH_READ_START + 2 * DEF_READ_BITS;
    localparam int SUB_DRIVE   = 0;
    localparam int SUB_RISE    = 1;
    localparam int MISO_LOW    = 0;
    localparam int MISO_HIGH   = 1;
    localparam int MISO_RANDOM = 2;
    localparam int TARGET_REQS = 1550;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    // pin sequencer and scaler predictor with the expected per-tick results
    class scan_tracker;
        logic [3:0]  n_sensors;
        logic [23:0] chan_map;
        logic [15:0] ext_lo;
        logic [15:0] ext_hi;
        logic [5:0]  step;
        logic [2:0]  sensor;
        logic [7:0]  cmd_sr;
        logic [11:0] rx_sr;
        bit          sweep_on;
        bit          cs_lvl;
        bit          sclk_lvl;
        bit          mosi_lvl;
        int          errors;
        sacs_result_t pins_due[$];

        function new();
            n_sensors = RST_SENSOR_COUNT;
            chan_map  = RST_CHANNEL_MAP;
            ext_lo    = RST_MIN_EXT;
            ext_hi    = RST_MAX_EXT;
            step      = '0;
            sensor    = '0;
            cmd_sr    = '0;
            rx_sr     = '0;
            sweep_on  = 1'b0;
            cs_lvl    = 1'b1;
            sclk_lvl  = 1'b0;
            mosi_lvl  = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(sacs_reg_t r, logic [31:0] v);
            case (r)
                REG_SENSOR_COUNT: n_sensors = v[3:0];
                REG_CHANNEL_MAP:  chan_map  = v[23:0];
                REG_MIN_EXT:      ext_lo    = v[15:0];
                REG_MAX_EXT:      ext_hi    = v[15:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pins_due.size();
        endfunction

        // min + code*(max-min)/full scale, rounded to nearest, saturated
        function logic [15:0] scaled(int unsigned code);
            longint lo;
            longint hi;
            longint num;
            longint q;
            longint s;
            lo  = longint'($signed(ext_lo));
            hi  = longint'($signed(ext_hi));
            num = longint'(code) * (hi - lo);
            if (num >= 0)
                q = (num + FULL_SCALE / 2) / FULL_SCALE;
            else
                q = -((-num + FULL_SCALE / 2) / FULL_SCALE);
            s = lo + q;
            if (s > 32767)
                s = 32767;
            if (s < -32768)
                s = -32768;
            return s[15:0];
        endfunction

        // one accepted tick request: advance the pin sequence
        function void note_tick(bit go, bit sdi);
            sacs_result_t r;
            int unsigned  p;
            int unsigned  k;
            int unsigned  code;
            int           eff;
            logic [2:0]   ch;
            r = '0;
            if (!sweep_on && go)
            begin
                sweep_on = 1'b1;
                sensor   = '0;
                step     = '0;
            end
            if (sweep_on)
            begin
                p = step;
                if (p == 0)
                    cs_lvl = 1'b1;
                else if (p == 1)
                    sclk_lvl = 1'b0;
                else if (p == 2)
                begin
                    ch     = chan_map[3 * sensor +: 3];
                    cs_lvl = 1'b0;
                    cmd_sr = {CMD_PREFIX, ch, 3'b000};
                    rx_sr  = '0;
                end
                else if (p < PH_READ_START)
                begin
                    // command bit: drive, rise, fall
                    k = (p - PH_CMD_START) % 3;
                    if (k == SUB_DRIVE)
                    begin
                        mosi_lvl = cmd_sr[7];
                        cmd_sr   = cmd_sr << 1;
                    end
                    else
                        sclk_lvl = (k == SUB_RISE);
                end
                else if (p < PH_END)
                begin
                    // read bit: sample on the falling tick
                    if (((p - PH_READ_START) % 2) == 0)
                        sclk_lvl = 1'b1;
                    else
                    begin
                        sclk_lvl = 1'b0;
                        rx_sr    = {rx_sr[10:0], sdi};
                    end
                end
                else
                begin
                    code    = rx_sr >> 1;
                    cs_lvl  = 1'b1;
                    r.valid = 1'b1;
                    r.idx   = sensor;
                    r.raw   = code[RAW_W-1:0];
                    r.ext   = scaled(code);
                    eff     = (n_sensors == 0) ? 1 : int'(n_sensors);
                    if (eff > DEF_MAX_SENSORS)
                        eff = DEF_MAX_SENSORS;
                    if (int'(sensor) + 1 >= eff)
                    begin
                        r.last   = 1'b1;
                        sweep_on = 1'b0;
                        sensor   = '0;
                    end
                    else
                        sensor = sensor + 3'd1;
                    step = '0;
                end
                if (!r.valid)
                    step = step + 6'd1;
            end
            r.cs   = cs_lvl;
            r.sclk = sclk_lvl;
            r.mosi = mosi_lvl;
            r.busy = sweep_on;
            pins_due.push_back(r);
        endfunction

        function void cmp(string field, logic signed [31:0] want, logic signed [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        // one popped result request against the oldest expectation
        function void check_tick(sacs_result_t got);
            sacs_result_t want;
            if (pins_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got cs=%0b sclk=%0b",
                         $time, got.cs, got.sclk);
                errors++;
                return;
            end
            want = pins_due.pop_front();
            cmp("chip_select", want.cs, got.cs);
            cmp("spi_clock", want.sclk, got.sclk);
            cmp("mosi", want.mosi, got.mosi);
            cmp("result_valid", want.valid, got.valid);
            cmp("sensor_index", want.idx, got.idx);
            cmp("raw_code", want.raw, got.raw);
            cmp("extension", $signed(want.ext), $signed(got.ext));
            cmp("last_sensor", want.last, got.last);
            cmp("busy_res", want.busy, got.busy);
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               push      = 1'b0;
    logic               full;
    logic               start_req = 1'b0;
    logic               miso      = 1'b0;
    logic               empty;
    logic               pop       = 1'b0;
    logic               chip_select;
    logic               spi_clock;
    logic               mosi;
    logic               result_valid;
    logic [2:0]         sensor_index;
    logic [RAW_W-1:0]   raw_code;
    logic signed [15:0] extension;
    logic               last_sensor;
    logic               busy_res;

    scan_tracker tracker;
    int          n_sent      = 0;
    int          quiet_count = 0;
    bit          hold_req    = 1'b0;
    bit          steady_send = 1'b0;
    bit          pop_eager   = 1'b0;

    spi_adc_channel_scan u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .start_req    (start_req),
        .miso         (miso),
        .empty        (empty),
        .pop          (pop),
        .chip_select  (chip_select),
        .spi_clock    (spi_clock),
        .mosi         (mosi),
        .result_valid (result_valid),
        .sensor_index (sensor_index),
        .raw_code     (raw_code),
        .extension    (extension),
        .last_sensor  (last_sensor),
        .busy_res     (busy_res)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // register write: setup then access, ends at a fresh falling edge
    task automatic apb_write(sacs_reg_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.write_reg(r, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // offer one tick request until accepted
    task automatic send_tick(bit go, bit sdi);
        push      <= 1'b1;
        start_req <= go;
        miso      <= sdi;
        do @(posedge clk); while (full);
        tracker.note_tick(go, sdi);
        n_sent++;
        @(negedge clk);
    endtask

    // sender idle: mostly none, some short, a few long
    task automatic sender_gap();
        int unsigned r;
        int unsigned n;
        r = $urandom_range(0, 99);
        if (steady_send || r < 70)
            return;
        n = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        push <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic bit pick_miso(int mode);
        if (mode == MISO_LOW)
            return 1'b0;
        if (mode == MISO_HIGH)
            return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // one full sweep; start_req noise while busy is ignored by the block
    task automatic run_sweep(int mode, int start_pct);
        sender_gap();
        send_tick(1'b1, pick_miso(mode));
        while (tracker.sweep_on)
        begin
            sender_gap();
            send_tick($urandom_range(0, 99) < start_pct, pick_miso(mode));
        end
    endtask

    // a few idle ticks between sweeps
    task automatic idle_ticks();
        repeat ($urandom_range(0, 3))
        begin
            sender_gap();
            send_tick(1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    // sender pause until every expected result has come back
    task automatic settle();
        push <= 1'b0;
        do @(negedge clk); while (tracker.pending() != 0);
    endtask

    // result side: pop with random stalls and one long hold-off
    initial
    begin
        int unsigned r;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                pop      <= 1'b0;
                hold_req  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (!pop_eager && r < 3)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
            else
                pop <= pop_eager || (r < 70);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        sacs_result_t got;
        if (rst_n && pop && !empty)
        begin
            got.cs    = chip_select;
            got.sclk  = spi_clock;
            got.mosi  = mosi;
            got.valid = result_valid;
            got.idx   = sensor_index;
            got.raw   = raw_code;
            got.ext   = extension;
            got.last  = last_sensor;
            got.busy  = busy_res;
            tracker.check_tick(got);
        end
    end

    // watchdog on cycles with no request accepted on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT)
        begin
            $display("** spi_adc_channel_scan: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        tracker = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: pins hold while idle, start held high through a sweep
        send_tick(1'b0, 1'b1);
        send_tick(1'b1 & 1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        run_sweep(MISO_HIGH, 100);
        settle();

        // one sensor, all channel bits set, full-range scale
        apb_write(REG_SENSOR_COUNT, 32'd1);
        apb_write(REG_CHANNEL_MAP, 32'h00FF_FFFF);
        apb_write(REG_MIN_EXT, 32'h0000_8000);
        apb_write(REG_MAX_EXT, 32'h0000_7FFF);
        run_sweep(MISO_LOW, 0);
        run_sweep(MISO_HIGH, 0);
        repeat (4)
        begin
            idle_ticks();
            run_sweep(MISO_RANDOM, 20);
        end
        settle();

        // zero count acts as one, channel zero, inverted scale
        apb_write(REG_SENSOR_COUNT, 32'hFFFF_FFF0);
        apb_write(REG_CHANNEL_MAP, 32'hFF00_0000);
        apb_write(REG_MIN_EXT, 32'h0000_7FFF);
        apb_write(REG_MAX_EXT, 32'hFFFF_8000);
        run_sweep(MISO_HIGH, 0);
        run_sweep(MISO_LOW, 0);
        repeat (3)
        begin
            idle_ticks();
            run_sweep(MISO_RANDOM, 20);
        end
        settle();

        // count above the maximum, long result hold-off while ticks keep coming
        apb_write(REG_SENSOR_COUNT, 32'd15);
        apb_write(REG_CHANNEL_MAP, $urandom());
        apb_write(REG_MIN_EXT, $urandom());
        apb_write(REG_MAX_EXT, $urandom());
        steady_send = 1'b1;
        hold_req    = 1'b1;
        run_sweep(MISO_RANDOM, 10);
        steady_send = 1'b0;

        // random settings until enough tick requests went in
        while (n_sent < TARGET_REQS)
        begin
            settle();
            apb_write(REG_SENSOR_COUNT, $urandom());
            apb_write(REG_CHANNEL_MAP, $urandom());
            apb_write(REG_MIN_EXT, $urandom());
            apb_write(REG_MAX_EXT, $urandom());
            steady_send = ($urandom_range(0, 3) == 0);
            pop_eager   = ($urandom_range(0, 3) == 0);
            repeat (2)
            begin
                idle_ticks();
                run_sweep(MISO_RANDOM, 10);
            end
        end
        steady_send = 1'b0;
        pop_eager   = 1'b0;

        settle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (tracker.errors == 0)
            $display("** spi_adc_channel_scan: PASSED **");
        else
            $display("** spi_adc_channel_scan: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/sacs_pkg.sv
design/sacs_queue.sv
design/sacs_front.sv
design/sacs_back.sv
design/spi_adc_channel_scan.sv
design/sacs_checker.sv
test/tb_spi_adc_channel_scan.sv
